[rtl/core/assert_macros.svh]
// Assertion helpers for the scheduler. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`else

`define CHK_SAME(lbl, clk, rst_n, ante, cons)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/core/mlfq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mlfq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int NUM_LEVELS  = 3;
  localparam int STORE_DEPTH = NUM_LEVELS * QUEUE_DEPTH;

  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int JOB_W   = 8;
  localparam int QUANT_W = 17;
  localparam int LVL_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CFG_IDX_W = 3;

  localparam logic [QUANT_W-1:0] RR_QUANTUM_RST  = QUANT_W'(8192);
  localparam logic [QUANT_W-1:0] HIGH_QUANTUM_RST = QUANT_W'(8192);
  localparam logic [QUANT_W-1:0] MED_QUANTUM_RST = QUANT_W'(65536);
  localparam logic [QUANT_W-1:0] LOW_QUANTUM_RST = QUANT_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE        = 3'd0,
    REG_RR_QUANTUM  = 3'd1,
    REG_HIGH_QUANTUM = 3'd2,
    REG_MED_QUANTUM = 3'd3,
    REG_LOW_QUANTUM = 3'd4
  } reg_idx_t;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic KIND_ADD  = 1'b0;
  localparam logic KIND_GET  = 1'b1;
  localparam logic MODE_RR   = 1'b0;

  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MED  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [JOB_W-1:0]   job_id;
    logic [QUANT_W-1:0] prior_quantum;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [JOB_W-1:0]   job_out;
    logic [LVL_W-1:0]   level_out;
    logic [QUANT_W-1:0] quantum_out;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } mlfq_cmd_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
    return (pos == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : pos + PTR_W'(1);
  endfunction

  function automatic logic [QUANT_W-1:0] level_quantum(
    input logic               mode,
    input logic [LVL_W-1:0]   lvl,
    input logic [QUANT_W-1:0] rr_q,
    input logic [QUANT_W-1:0] high_q,
    input logic [QUANT_W-1:0] med_q,
    input logic [QUANT_W-1:0] low_q
  );
    logic [QUANT_W-1:0] q;
    if (mode == MODE_RR) begin
      q = rr_q;
    end else if (lvl == LVL_HIGH) begin
      q = high_q;
    end else if (lvl == LVL_MED) begin
      q = med_q;
    end else begin
      q = low_q;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

[rtl/core/mlfq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/mlfq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module mlfq_ctrl
  import mlfq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  output logic      out_valid,
  output mlfq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;
  logic   valid_r, valid_nxt;
  logic   accept;

  assign accept = start && !busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // The result is shown while the next item may already be taken.
        state_nxt = accept ? S_EXEC : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    busy_nxt  = (state_nxt == S_EXEC);
    valid_nxt = (state_nxt == S_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;
  assign cmd.load  = accept;
  assign cmd.exec  = (state_r == S_EXEC);

endmodule

`default_nettype wire

[rtl/core/mlfq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module mlfq_dp
  import mlfq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire mlfq_cmd_t            cmd,
  input  wire in_item_t             in_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [QUANT_W-1:0]   cfg_data,
  output out_item_t                 out_data
);

  // Configuration registers.
  logic               mode_r;
  logic [QUANT_W-1:0] rr_q_r, high_q_r, med_q_r, low_q_r;

  // Captured item.
  logic               kind_r;
  logic [JOB_W-1:0]   job_in_r;
  logic [QUANT_W-1:0] prior_r;

  // Queue bookkeeping.
  logic [PTR_W-1:0] head_r [NUM_LEVELS];
  logic [PTR_W-1:0] tail_r [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_r  [NUM_LEVELS];
  logic [PTR_W-1:0] head_nxt [NUM_LEVELS];
  logic [PTR_W-1:0] tail_nxt [NUM_LEVELS];
  logic [CNT_W-1:0] cnt_nxt  [NUM_LEVELS];

  // Result registers.
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic [JOB_W-1:0]   job_r, job_nxt;
  logic [LVL_W-1:0]   level_r, level_nxt;
  logic [QUANT_W-1:0] quant_r, quant_nxt;
  logic               from_ram_r, from_ram_nxt;

  logic [LVL_W-1:0]  lvl_add, lvl_get, lvl;
  logic              found, full;
  logic [PTR_W-1:0]  ptr;
  logic [ADDR_W-1:0] addr;
  logic              ram_we, ram_re;
  logic [JOB_W-1:0]  ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_RR;
      rr_q_r   <= RR_QUANTUM_RST;
      high_q_r <= HIGH_QUANTUM_RST;
      med_q_r  <= MED_QUANTUM_RST;
      low_q_r  <= LOW_QUANTUM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:         mode_r   <= cfg_data[0];
        REG_RR_QUANTUM:   rr_q_r   <= cfg_data;
        REG_HIGH_QUANTUM: high_q_r <= cfg_data;
        REG_MED_QUANTUM:  med_q_r  <= cfg_data;
        REG_LOW_QUANTUM:  low_q_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_data.kind;
      job_in_r <= in_data.job_id;
      prior_r  <= in_data.prior_quantum;
    end
  end

  always_comb begin
    if (mode_r == MODE_RR || prior_r == '0) begin
      lvl_add = LVL_HIGH;
    end else if (prior_r == high_q_r) begin
      lvl_add = LVL_MED;
    end else begin
      lvl_add = LVL_LOW;
    end

    // Lowest non-empty level wins; scan from the back so it is written last.
    found   = 1'b0;
    lvl_get = LVL_HIGH;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (cnt_r[i] != '0) begin
        found   = 1'b1;
        lvl_get = LVL_W'(i);
      end
    end

    lvl  = (kind_r == KIND_ADD) ? lvl_add : lvl_get;
    full = (cnt_r[lvl] == CNT_W'(QUEUE_DEPTH));
    ptr  = (kind_r == KIND_ADD) ? tail_r[lvl] : head_r[lvl];
    addr = ADDR_W'(lvl) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);

    ram_we = cmd.exec && (kind_r == KIND_ADD) && !full;
    ram_re = cmd.exec && (kind_r == KIND_GET) && found;

    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_nxt[i] = head_r[i];
      tail_nxt[i] = tail_r[i];
      cnt_nxt[i]  = cnt_r[i];
    end
    if (ram_we) begin
      tail_nxt[lvl] = ring_next(tail_r[lvl]);
      cnt_nxt[lvl]  = cnt_r[lvl] + CNT_W'(1);
    end
    if (ram_re) begin
      head_nxt[lvl] = ring_next(head_r[lvl]);
      cnt_nxt[lvl]  = cnt_r[lvl] - CNT_W'(1);
    end

    status_nxt   = ST_OK;
    job_nxt      = '0;
    level_nxt    = '0;
    quant_nxt    = '0;
    from_ram_nxt = 1'b0;
    if (kind_r == KIND_ADD) begin
      level_nxt = lvl;
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        job_nxt   = job_in_r;
        quant_nxt = level_quantum(mode_r, lvl, rr_q_r, high_q_r, med_q_r, low_q_r);
      end
    end else if (found) begin
      level_nxt    = lvl;
      quant_nxt    = level_quantum(mode_r, lvl, rr_q_r, high_q_r, med_q_r, low_q_r);
      from_ram_nxt = 1'b1;
    end else begin
      status_nxt = ST_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= '0;
        tail_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        head_r[i] <= head_nxt[i];
        tail_r[i] <= tail_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r   <= status_nxt;
      job_r      <= job_nxt;
      level_r    <= level_nxt;
      quant_r    <= quant_nxt;
      from_ram_r <= from_ram_nxt;
    end
  end

  mlfq_ram #(
    .WIDTH (JOB_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (job_in_r),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign out_data.status      = status_r;
  assign out_data.job_out     = from_ram_r ? ram_rdata : job_r;
  assign out_data.level_out   = level_r;
  assign out_data.quantum_out = quant_r;

endmodule

`default_nettype wire

[rtl/core/multilevel_feedback_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none

// Three-level job scheduler with FIFO queues of job IDs.
// Input: assert start with in_data; the item is taken at a clock edge where
// start is high and busy is low. An add item files a job into a level chosen
// by mode and prior_quantum; a get item dequeues from the first non-empty level.
// Output: every item gives exactly one result, shown on out_data for a single
// cycle while out_valid is high. The receiver cannot stall; it must take the
// result in that cycle.
// The accepted item is worked on in the EXEC state; the result appears in the
// DONE state and is taken at the edge that ends it. A new item is not taken
// until the previous one reaches its result cycle: the EXEC cycle does the
// level choice and the job store access, whose registered read returns in the
// result cycle, and the next item may be taken at the edge that ends that cycle.
// Configuration: cfg_we, cfg_index and cfg_data write one register per cycle;
// write only while no item is in flight. Unknown indexes are ignored.
// Reset (rst_n low, synchronous) empties all queues and restores the register
// defaults at once; the job store itself is not cleared and needs no sweep.

module multilevel_feedback_scheduler
  import mlfq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  output out_item_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [QUANT_W-1:0]   cfg_data
);

  mlfq_cmd_t cmd;

  mlfq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mlfq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

`include "assert_macros.svh"

  `CHK_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy && !out_valid)
  `CHK_NEXT(a_busy_gives_result, clk, rst_n, busy, out_valid && !busy)
  `CHK_SAME(a_result_not_busy, clk, rst_n, out_valid, !busy)
  `CHK_SAME(a_error_has_no_job, clk, rst_n,
            out_valid && out_data.status != ST_OK, out_data.job_out == '0)

endmodule

`default_nettype wire

[bench/mlfq_checker.sv]
`timescale 1ns / 1ps

module mlfq_checker
  import mlfq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [QUANT_W-1:0]   cfg_data,
  output int                   errors,
  output int                   pending
);

  logic               mode_q;
  logic [QUANT_W-1:0] rr_q;
  logic [QUANT_W-1:0] high_q;
  logic [QUANT_W-1:0] med_q;
  logic [QUANT_W-1:0] low_q;

  logic [JOB_W-1:0] job_ring [NUM_LEVELS][QUEUE_DEPTH];
  int               rd_pos [NUM_LEVELS];
  int               wr_pos [NUM_LEVELS];
  int               occupancy [NUM_LEVELS];

  out_item_t awaited_grants[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // The quantum always follows the registers as they stand now, not the
  // ones in force when the job was queued.
  function automatic logic [QUANT_W-1:0] grant_for(input int lvl);
    logic [QUANT_W-1:0] q;
    if (mode_q == MODE_RR) begin
      q = rr_q;
    end else begin
      case (lvl)
        LVL_HIGH: q = high_q;
        LVL_MED:  q = med_q;
        default:  q = low_q;
      endcase
    end
    return q;
  endfunction

  function automatic out_item_t schedule_one(input in_item_t it);
    out_item_t r;
    int        lvl;
    r = '0;
    if (it.kind == KIND_ADD) begin
      if (mode_q == MODE_RR || it.prior_quantum == '0) begin
        lvl = LVL_HIGH;
      end else if (it.prior_quantum == high_q) begin
        lvl = LVL_MED;
      end else begin
        lvl = LVL_LOW;
      end
      r.level_out = LVL_W'(lvl);
      if (occupancy[lvl] >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        job_ring[lvl][wr_pos[lvl]] = it.job_id;
        wr_pos[lvl] = (wr_pos[lvl] + 1) % QUEUE_DEPTH;
        occupancy[lvl]++;
        r.status      = ST_OK;
        r.job_out     = it.job_id;
        r.quantum_out = grant_for(lvl);
      end
    end else begin
      r.status = ST_EMPTY;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        if (r.status == ST_EMPTY && occupancy[l] != 0) begin
          r.status      = ST_OK;
          r.job_out     = job_ring[l][rd_pos[l]];
          r.level_out   = LVL_W'(l);
          r.quantum_out = grant_for(l);
          rd_pos[l] = (rd_pos[l] + 1) % QUEUE_DEPTH;
          occupancy[l]--;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    logic      bad;
    if (!rst_n) begin
      mode_q = MODE_RR;
      rr_q   = RR_QUANTUM_RST;
      high_q = HIGH_QUANTUM_RST;
      med_q  = MED_QUANTUM_RST;
      low_q  = LOW_QUANTUM_RST;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        rd_pos[l]    = 0;
        wr_pos[l]    = 0;
        occupancy[l] = 0;
      end
      awaited_grants.delete();
    end else begin
      // Results are compared before this edge's input transfer is predicted.
      if (out_valid) begin
        if (awaited_grants.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result, expected none, got %h", $time, out_data);
        end else begin
          want = awaited_grants.pop_front();
          bad  = 1'b0;
          if (out_data.status !== want.status) begin
            bad = 1'b1;
            $display("%0t ns: status expected %0d, got %0d",
                     $time, want.status, out_data.status);
          end
          if (out_data.job_out !== want.job_out) begin
            bad = 1'b1;
            $display("%0t ns: job_out expected %h, got %h",
                     $time, want.job_out, out_data.job_out);
          end
          if (out_data.level_out !== want.level_out) begin
            bad = 1'b1;
            $display("%0t ns: level_out expected %0d, got %0d",
                     $time, want.level_out, out_data.level_out);
          end
          if (out_data.quantum_out !== want.quantum_out) begin
            bad = 1'b1;
            $display("%0t ns: quantum_out expected %0d, got %0d",
                     $time, want.quantum_out, out_data.quantum_out);
          end
          if (bad) begin
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:         mode_q = cfg_data[0];
          REG_RR_QUANTUM:   rr_q   = cfg_data;
          REG_HIGH_QUANTUM: high_q = cfg_data;
          REG_MED_QUANTUM:  med_q  = cfg_data;
          REG_LOW_QUANTUM:  low_q  = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        awaited_grants.push_back(schedule_one(in_data));
      end
    end
    pending = awaited_grants.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mlfq_pkg::*;

  localparam logic MODE_MLFQ   = 1'b1;
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   SETTLE_CYC  = 4;
  localparam int   IDX_SPARE_LO = int'(REG_LOW_QUANTUM) + 1;
  localparam int   IDX_SPARE_HI = (1 << CFG_IDX_W) - 1;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [QUANT_W-1:0]   cfg_data  = '0;

  int                 errors;
  int                 pending;
  int                 cycles   = 0;
  logic [QUANT_W-1:0] cur_high = HIGH_QUANTUM_RST;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  multilevel_feedback_scheduler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mlfq_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Start stays high across back-to-back items so that it never gets two
  // assignments in one time step.
  task automatic submit(input logic kind, input logic [JOB_W-1:0] job,
                        input logic [QUANT_W-1:0] prior, input int gap);
    in_item_t it;
    it.kind          = kind;
    it.job_id        = job;
    it.prior_quantum = prior;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Writes all five registers, then one write to an unused index that the
  // block must ignore.
  task automatic program_regs(input logic mode, input logic [QUANT_W-1:0] rr,
                              input logic [QUANT_W-1:0] hi,
                              input logic [QUANT_W-1:0] med,
                              input logic [QUANT_W-1:0] lo);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= {16'($urandom), mode};
    @(posedge clk);
    cfg_index <= REG_RR_QUANTUM;
    cfg_data  <= rr;
    @(posedge clk);
    cfg_index <= REG_HIGH_QUANTUM;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_index <= REG_MED_QUANTUM;
    cfg_data  <= med;
    @(posedge clk);
    cfg_index <= REG_LOW_QUANTUM;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= CFG_IDX_W'($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI));
    cfg_data  <= QUANT_W'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_high = hi;
  endtask

  function automatic logic [QUANT_W-1:0] pick_quantum();
    logic [QUANT_W-1:0] q;
    case ($urandom_range(0, 5))
      0:       q = QUANT_W'(1);
      1:       q = QUANT_W'(65536);
      2:       q = '1;
      3:       q = '0;
      default: q = QUANT_W'($urandom);
    endcase
    return q;
  endfunction

  // A third of the priors match the high quantum so that demotion is common.
  function automatic logic [QUANT_W-1:0] pick_prior();
    logic [QUANT_W-1:0] q;
    case ($urandom_range(0, 2))
      0:       q = '0;
      1:       q = cur_high;
      default: q = QUANT_W'($urandom);
    endcase
    return q;
  endfunction

  function automatic int pick_gap(input bit steady);
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (steady || r < 60) begin
      g = 0;
    end else if (r < 92) begin
      g = $urandom_range(1, 3);
    end else begin
      g = $urandom_range(8, 40);
    end
    return g;
  endfunction

  initial begin
    int   n_items;
    int   add_pct;
    logic mode;
    bit   steady;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values: round robin, everything lands in the top queue.
    submit(KIND_GET, 8'h5A, '1, 1);
    submit(KIND_ADD, 8'h00, '0, 0);
    submit(KIND_ADD, 8'hFF, '1, 0);
    submit(KIND_ADD, 8'h81, HIGH_QUANTUM_RST, 2);
    submit(KIND_GET, '0, '0, 0);
    submit(KIND_GET, '1, '1, 0);
    submit(KIND_GET, '0, '0, 3);
    submit(KIND_GET, '0, '0, 0);
    settle();

    // Feedback mode: new job, demoted job, and three that fall to the bottom.
    program_regs(MODE_MLFQ, QUANT_W'(1), QUANT_W'(5), QUANT_W'(65536), '1);
    submit(KIND_ADD, 8'h11, '0, 0);
    submit(KIND_ADD, 8'h22, QUANT_W'(5), 0);
    submit(KIND_ADD, 8'h33, QUANT_W'(1), 1);
    submit(KIND_ADD, 8'h44, '1, 0);
    submit(KIND_ADD, 8'h55, QUANT_W'(65536), 0);
    submit(KIND_GET, '0, '0, 0);
    submit(KIND_GET, '0, '0, 0);
    submit(KIND_GET, '0, '0, 2);
    settle();

    // Jobs left in the bottom queue are served under round-robin quanta.
    program_regs(MODE_RR, QUANT_W'(65536), '0, QUANT_W'(1), '0);
    submit(KIND_GET, '0, '0, 0);
    submit(KIND_GET, '0, '0, 0);
    submit(KIND_GET, '0, '0, 0);

    // The first phase overfills the top queue; later ones alternate between
    // filling and draining with fresh register settings.
    for (int p = 0; p < 10; p++) begin
      settle();
      if (p == 0) begin
        mode = MODE_RR;
      end else if (p == 3) begin
        mode = MODE_MLFQ;
      end else begin
        mode = 1'($urandom);
      end
      program_regs(mode, pick_quantum(), pick_quantum(), pick_quantum(), pick_quantum());
      add_pct = (p % 3 == 0) ? 95 : ((p % 3 == 1) ? 25 : 55);
      n_items = (p == 0) ? 80 : 35;
      steady  = (p % 4 == 1);
      for (int i = 0; i < n_items; i++) begin
        submit(($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_GET,
               JOB_W'($urandom), pick_prior(), pick_gap(steady));
      end
    end
    settle();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mlfq_pkg.sv
rtl/core/mlfq_ram.sv
rtl/core/mlfq_ctrl.sv
rtl/core/mlfq_dp.sv
rtl/core/multilevel_feedback_scheduler.sv
bench/mlfq_checker.sv
bench/tb_top.sv
